>>> hdl/lge_pkg.sv
// Shared types and constants for the life grid generation engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package lge_pkg;

    // Default grid bounds for the top-level parameters.
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    // Size registers
    localparam int        CFG_W     = 7;
    localparam int        APB_AW    = 3;
    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;
    localparam logic      REG_WIDTH_IDX  = 1'b0;
    localparam logic      REG_HEIGHT_IDX = 1'b1;

    // Life rule neighbor counts
    localparam logic [3:0] LIVE_BIRTH = 4'd3;
    localparam logic [3:0] LIVE_KEEP  = 4'd2;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_GEN   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_GEN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

>>> hdl/lge_mem.sv
// Row store of the cell grid: one row per entry, one write and one read port.
// Read data is registered. Uses lge_pkg.
`default_nettype none

module lge_mem
    import lge_pkg::*;
#(
    parameter int DEPTH = MAX_HEIGHT_DEF,
    parameter int WIDTH = MAX_WIDTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire t_mem_ctl         i_ctl,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/lge_rule.sv
// Next-generation logic for one grid row from the rows above, at and below it.
// Columns wrap at the in-use width; columns beyond it keep their value. Uses lge_pkg.
`default_nettype none

module lge_rule
    import lge_pkg::*;
#(
    parameter int WIDTH = MAX_WIDTH_DEF,
    parameter int CW    = (WIDTH > 1) ? $clog2(WIDTH) : 1,
    parameter int WW    = (CW + 1 > CFG_W) ? CW + 1 : CFG_W
) (
    input  wire logic [WIDTH-1:0] i_up,
    input  wire logic [WIDTH-1:0] i_mid,
    input  wire logic [WIDTH-1:0] i_dn,
    input  wire logic [WW-1:0]    i_w_eff,
    output logic      [WIDTH-1:0] o_next
);

    logic [CW-1:0] w_last;

    assign w_last = CW'(i_w_eff - WW'(1));

    always_comb begin
        logic [CW-1:0] li;
        logic [CW-1:0] ri;
        logic [CW-1:0] ci;
        logic [3:0]    cnt;
        o_next = i_mid;
        for (int c = 0; c < WIDTH; c++) begin
            ci  = CW'(c);
            li  = (ci == '0) ? w_last : ci - CW'(1);
            ri  = (ci == w_last) ? '0 : ci + CW'(1);
            cnt = {3'b0, i_up[li]} + {3'b0, i_up[ci]} + {3'b0, i_up[ri]}
                + {3'b0, i_mid[li]} + {3'b0, i_mid[ri]}
                + {3'b0, i_dn[li]} + {3'b0, i_dn[ci]} + {3'b0, i_dn[ri]};
            if (WW'(c) < i_w_eff) begin
                o_next[c] = (cnt == LIVE_BIRTH) || (i_mid[c] && (cnt == LIVE_KEEP));
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/life_grid_generation_engine.sv
// Toroidal Game of Life engine. The grid is held one row per memory entry. A write or
// read request inside the in-use grid reads its row, then modifies or selects the cell,
// before its result is loaded into the output register. A write or read outside the in-use
// grid, or a no-op, skips the row read. For a generation request the sequencer streams one
// row per cycle through the single memory read port, fills a three-row window first, and
// writes each new row back two rows behind the read pointer. The next request is taken in
// the cycle after the result is loaded. A result that waits on a held-off output holds the
// engine until the output register frees up. After reset a clearing pass writes every row
// to dead, during which no request is taken. Write the size registers only while no request
// is in flight. Requests are handled one at a time; a finished result may wait in the
// output register while the next request is already accepted. Depends on lge_pkg, lge_mem,
// lge_rule.
`default_nettype none

module life_grid_generation_engine
    import lge_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [15:0]        s_tdata,   // req_type[1:0] row[7:2] column[13:8] cell_in[14]
    // result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,   // cell_out[0] status[1]
    // register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int HW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int GW = HW + 1;

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_width, r_height;
    logic [AW-1:0]    r_clr_addr;
    logic [GW-1:0]    r_gstep;
    logic [AW-1:0]    r_gaddr;
    logic [AW-1:0]    r_wrow;
    t_req             r_req;
    logic [5:0]       r_row, r_col;
    logic             r_cell;
    logic [MAX_WIDTH-1:0] r_up, r_mid, r_row0;
    logic             r_res_cell, r_res_status, n_res_cell, n_res_status;
    logic             r_m_valid;
    logic [1:0]       r_m_data;

    logic [HW-1:0]    h_ext, h_eff;
    logic [WW-1:0]    w_ext, w_eff;
    logic [AW-1:0]    h_last;
    logic [GW-1:0]    g_end;
    logic             accept, out_load, outside, cfg_wr;
    t_req             in_req;
    logic [5:0]       in_row, in_col;
    logic [CW-1:0]    col_idx;
    t_mem_ctl         mem_ctl;
    logic [AW-1:0]    mem_wr_addr, mem_rd_addr;
    logic [MAX_WIDTH-1:0] mem_wr_data, mem_rd_data, gen_dn, gen_next;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HEIGHT_IDX) ? {25'b0, r_height} : {25'b0, r_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_RESET;
            r_height <= SIZE_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH_IDX) begin
                r_width <= pwdata[CFG_W-1:0];
            end else begin
                r_height <= pwdata[CFG_W-1:0];
            end
        end
    end

    // Clamp sizes into 1..MAX
    assign h_ext  = HW'(r_height);
    assign w_ext  = WW'(r_width);
    assign h_eff  = (r_height == '0) ? HW'(1) :
                    (h_ext > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : h_ext;
    assign w_eff  = (r_width == '0) ? WW'(1) :
                    (w_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_ext;
    assign h_last = AW'(h_eff - HW'(1));
    assign g_end  = GW'(h_eff) + GW'(2);

    assign in_req  = t_req'(s_tdata[1:0]);
    assign in_row  = s_tdata[7:2];
    assign in_col  = s_tdata[13:8];
    assign outside = (HW'(in_row) >= h_eff) || (WW'(in_col) >= w_eff);
    assign accept  = s_tvalid && s_tready;
    assign col_idx = CW'(r_col);

    // The last row wraps onto the saved copy of the old first row
    assign gen_dn = (r_gstep == g_end) ? r_row0 : mem_rd_data;

    lge_mem #(
        .DEPTH (MAX_HEIGHT),
        .WIDTH (MAX_WIDTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    lge_rule #(
        .WIDTH (MAX_WIDTH),
        .CW    (CW),
        .WW    (WW)
    ) u_rule (
        .i_up    (r_up),
        .i_mid   (r_mid),
        .i_dn    (gen_dn),
        .i_w_eff (w_eff),
        .o_next  (gen_next)
    );

    always_comb begin
        n_state      = r_state;
        n_res_cell   = r_res_cell;
        n_res_status = r_res_status;
        mem_ctl      = '0;
        mem_wr_addr  = r_clr_addr;
        mem_wr_data  = '0;
        mem_rd_addr  = AW'(in_row);
        s_tready     = 1'b0;
        out_load     = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_ctl.wr_en = 1'b1;
                if (r_clr_addr == AW'(MAX_HEIGHT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    n_res_cell   = 1'b0;
                    n_res_status = 1'b0;
                    case (in_req)
                        REQ_WRITE, REQ_READ: begin
                            if (outside) begin
                                n_res_status = 1'b1;
                                n_state      = ST_RESULT;
                            end else begin
                                mem_ctl.rd_en = 1'b1;
                                n_state       = ST_CELL;
                            end
                        end
                        REQ_GEN: n_state = ST_GEN;
                        default: n_state = ST_RESULT;
                    endcase
                end
            end
            ST_CELL: begin
                mem_wr_addr = AW'(r_row);
                mem_wr_data = mem_rd_data;
                if (r_req == REQ_WRITE) begin
                    mem_ctl.wr_en        = 1'b1;
                    mem_wr_data[col_idx] = r_cell;
                end else begin
                    n_res_cell = mem_rd_data[col_idx];
                end
                n_state = ST_RESULT;
            end
            ST_GEN: begin
                mem_rd_addr   = r_gaddr;
                mem_ctl.rd_en = (r_gstep <= GW'(h_eff));
                mem_wr_addr   = r_wrow;
                mem_wr_data   = gen_next;
                // write back two rows behind the read pointer
                if (r_gstep >= GW'(3)) begin
                    mem_ctl.wr_en = 1'b1;
                end
                if (r_gstep == g_end) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_m_valid || m_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_gstep    <= '0;
            r_gaddr    <= '0;
            r_wrow     <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (accept) begin
                r_gstep <= '0;
                r_gaddr <= h_last;
                r_wrow  <= '0;
            end else if (r_state == ST_GEN) begin
                r_gstep <= r_gstep + GW'(1);
                r_gaddr <= (r_gaddr == h_last) ? '0 : r_gaddr + AW'(1);
                if (r_gstep >= GW'(3)) begin
                    r_wrow <= r_wrow + AW'(1);
                end
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_cell   <= n_res_cell;
        r_res_status <= n_res_status;
        if (accept) begin
            r_req  <= in_req;
            r_row  <= in_row;
            r_col  <= in_col;
            r_cell <= s_tdata[14];
        end
        // shift the three-row window as rows arrive
        if (r_state == ST_GEN && r_gstep != '0) begin
            r_up  <= r_mid;
            r_mid <= gen_dn;
            if (r_gstep == GW'(2)) begin
                r_row0 <= mem_rd_data;
            end
        end
        if (out_load) begin
            r_m_data <= {r_res_status, r_res_cell};
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {6'b0, r_m_data};

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en && (mem_wr_addr == mem_rd_addr)))
        else $error("row read and write to the same entry in one cycle");

    a_gen_write_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GEN) && mem_ctl.wr_en |-> (mem_wr_addr <= h_last))
        else $error("generation wrote a row outside the in-use grid");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_tready)
        else $error("request accepted while another is in flight");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !s_tready && !m_tvalid)
        else $error("stream active during clearing pass");

endmodule

`default_nettype wire

>>> tb/life_grid_generation_engine_test.sv
// Self-checking test of the toroidal life grid engine: cell writes, reads and generations
// are predicted here and compared with every result. Depends on lge_pkg and the block.
`timescale 1ns / 1ps

module life_grid_generation_engine_test;
    import lge_pkg::*;

    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  HOLD_CYCLES    = 300;
    localparam int  DRAIN_CYCLES   = 80;
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    // idle schemes: sender light / receiver heavy, the reverse, and none
    localparam int IDLE_SEND_LIGHT = 0;
    localparam int IDLE_RECV_LIGHT = 1;
    localparam int IDLE_NONE       = 2;

    typedef struct packed {
        logic cell_val;
        logic status;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;   // req_type[1:0] row[7:2] column[13:8] cell_in[14]
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;         // cell_out[0] status[1]
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    life_grid_generation_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicted block state
    logic [MAX_WIDTH_DEF-1:0] life_grid [MAX_HEIGHT_DEF];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    logic [15:0]  pending_requests [$];
    t_result      expected_results [$];
    int requests_queued = 0;
    int requests_taken = 0;
    int results_checked = 0;
    int mismatches = 0;
    int idle_mode = IDLE_SEND_LIGHT;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;
    t_result want_result;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int grid_extent(logic [CFG_W-1:0] v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic void advance_generation();
        logic [MAX_WIDTH_DEF-1:0] prev [MAX_HEIGHT_DEF];
        int w, h, nb, rr, cc;
        prev = life_grid;
        w = grid_extent(width_reg, MAX_WIDTH_DEF);
        h = grid_extent(height_reg, MAX_HEIGHT_DEF);
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                nb = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) begin
                            rr = (r + h + dr) % h;
                            cc = (c + w + dc) % w;
                            nb += prev[rr][cc];
                        end
                    end
                end
                life_grid[r][c] = (nb == LIVE_BIRTH) || (prev[r][c] && nb == LIVE_KEEP);
            end
        end
    endfunction

    function automatic t_result apply_request(logic [15:0] word);
        t_result res;
        t_req kind;
        int r, c;
        logic outside;
        kind = t_req'(word[1:0]);
        r = int'(word[7:2]);
        c = int'(word[13:8]);
        outside = (r >= grid_extent(height_reg, MAX_HEIGHT_DEF)) ||
                  (c >= grid_extent(width_reg, MAX_WIDTH_DEF));
        res.cell_val = 1'b0;
        res.status = STATUS_DONE;
        case (kind)
            REQ_WRITE: begin
                if (outside) res.status = STATUS_OUTSIDE;
                else life_grid[r][c] = word[14];
            end
            REQ_GEN: advance_generation();
            REQ_READ: begin
                if (outside) res.status = STATUS_OUTSIDE;
                else res.cell_val = life_grid[r][c];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // mostly in range, often at the wrap seam, sometimes anywhere in the field
    function automatic logic [5:0] pick_coord(int n);
        int k;
        k = $urandom_range(0, 99);
        if (k < 12) return 6'($urandom_range(0, 63));
        if (k < 55) return 6'($urandom_range(0, n - 1));
        k = $urandom_range(0, 3) % n;
        return 6'(($urandom_range(0, 1) == 1) ? k : n - 1 - k);
    endfunction

    task automatic queue_request(t_req kind, int r, int c, logic v);
        pending_requests.push_back({1'b0, v, 6'(c), 6'(r), kind});
        requests_queued++;
    endtask

    task automatic queue_random(int count);
        int w, h, k;
        t_req kind;
        w = grid_extent(width_reg, MAX_WIDTH_DEF);
        h = grid_extent(height_reg, MAX_HEIGHT_DEF);
        repeat (count) begin
            k = $urandom_range(0, 99);
            if (k < 55) kind = REQ_WRITE;
            else if (k < 85) kind = REQ_READ;
            else if (k < 95) kind = REQ_GEN;
            else kind = REQ_NOP;
            queue_request(kind, pick_coord(h), pick_coord(w), roll(45));
        end
    endtask

    task automatic wait_drained();
        while (results_checked != requests_queued) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_size_reg(logic idx, logic [CFG_W-1:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= APB_AW'({idx, 2'b00});
        pwdata <= {25'($urandom_range(0, 32'h1ff_ffff)), v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_WIDTH_IDX) width_reg = v;
        else height_reg = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_grid_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        wait_drained();
        write_size_reg(REG_WIDTH_IDX, w);
        write_size_reg(REG_HEIGHT_IDX, h);
        // read back the height register, still addressed
        @(posedge i_clk);
        if (prdata !== {25'b0, h}) begin
            $display("%0t: height register expected %0d actual %0d", $time, h, prdata);
            mismatches++;
        end
    endtask

    // request driver: predict on acceptance, then load the next request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_request(s_tdata));
                requests_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 &&
                    !roll(idle_mode == IDLE_SEND_LIGHT ? 6 :
                          idle_mode == IDLE_RECV_LIGHT ? 56 : 0)) begin
                    s_tdata <= pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and ready pacing
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual cell_out %0d status %0d",
                         $time, m_tdata[0], m_tdata[1]);
                mismatches++;
            end else begin
                want_result = expected_results.pop_front();
                if (m_tdata[0] !== want_result.cell_val) begin
                    $display("%0t: cell_out expected %0d actual %0d",
                             $time, want_result.cell_val, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[1] !== want_result.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want_result.status, m_tdata[1]);
                    mismatches++;
                end
            end
            results_checked++;
        end
        // hold off once for a long stretch so the block backs up its input
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && requests_taken >= 30) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !roll(idle_mode == IDLE_SEND_LIGHT ? 56 :
                              idle_mode == IDLE_RECV_LIGHT ? 6 : 0);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        foreach (life_grid[r]) life_grid[r] = '0;
        width_reg = SIZE_RESET;
        height_reg = SIZE_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full 64 x 64 grid from reset: corners, a blinker across the column seam
        idle_mode = IDLE_SEND_LIGHT;
        queue_request(REQ_READ, 0, 0, 1'b0);
        queue_request(REQ_WRITE, 0, 0, 1'b1);
        queue_request(REQ_READ, 0, 0, 1'b0);
        queue_request(REQ_WRITE, 63, 63, 1'b1);
        queue_request(REQ_READ, 63, 63, 1'b0);
        queue_request(REQ_WRITE, 0, 63, 1'b1);
        queue_request(REQ_WRITE, 0, 1, 1'b1);
        queue_request(REQ_GEN, 0, 0, 1'b0);
        queue_request(REQ_READ, 63, 0, 1'b0);
        queue_request(REQ_READ, 1, 0, 1'b0);
        queue_request(REQ_NOP, 63, 63, 1'b1);
        queue_request(REQ_WRITE, 5, 5, 1'b0);
        queue_request(REQ_GEN, 63, 63, 1'b1);
        queue_request(REQ_READ, 0, 0, 1'b0);
        queue_random(70);

        // small torus: drop writes and zero reads just past each edge
        set_grid_size(7'd5, 7'd3);
        queue_request(REQ_WRITE, 3, 0, 1'b1);
        queue_request(REQ_WRITE, 0, 5, 1'b1);
        queue_request(REQ_READ, 63, 63, 1'b0);
        queue_request(REQ_WRITE, 2, 4, 1'b1);
        queue_request(REQ_READ, 2, 4, 1'b0);
        queue_request(REQ_GEN, 63, 63, 1'b0);
        queue_random(60);

        // zero sizes act as a single cell that is its own eight neighbors
        set_grid_size(7'd0, 7'd0);
        queue_request(REQ_WRITE, 0, 0, 1'b1);
        queue_request(REQ_GEN, 0, 0, 1'b0);
        queue_request(REQ_READ, 0, 0, 1'b0);
        queue_request(REQ_READ, 0, 1, 1'b0);
        queue_random(25);

        // oversized values clamp to the maximum; cells outside kept their values
        idle_mode = IDLE_RECV_LIGHT;
        set_grid_size(7'd127, 7'd100);
        queue_request(REQ_READ, 63, 63, 1'b0);
        queue_random(45);
        set_grid_size(7'd1, 7'd64);
        queue_random(40);
        set_grid_size(7'd64, 7'd1);
        queue_random(40);

        idle_mode = IDLE_NONE;
        for (int i = 0; i < 4; i++) begin
            set_grid_size(7'($urandom_range(1, 20)), 7'($urandom_range(1, 20)));
            queue_random(40);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
